// ===== rtl/sta_pkg.sv =====
// Shared constants, command type and scan code table for the scan code to ASCII unit.
package sta_pkg;

  localparam int BUFFER_DEPTH = 128;
  localparam int PTR_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CHAR_W       = 7;
  localparam int CODE_W       = 8;
  localparam int Q_DEPTH      = 2;
  localparam int Q_IDX_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] CMD_NOP   = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  // Set 1 make code to ASCII, US layout; unlisted codes give zero.
  function automatic logic [CHAR_W-1:0] set1_to_ascii(input logic [CODE_W-2:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      7'h01: c = 7'h1B;
      7'h02: c = 7'h31;
      7'h03: c = 7'h32;
      7'h04: c = 7'h33;
      7'h05: c = 7'h34;
      7'h06: c = 7'h35;
      7'h07: c = 7'h36;
      7'h08: c = 7'h37;
      7'h09: c = 7'h38;
      7'h0A: c = 7'h39;
      7'h0B: c = 7'h30;
      7'h0C: c = 7'h2D;
      7'h0D: c = 7'h3D;
      7'h0E: c = 7'h08;
      7'h0F: c = 7'h09;
      7'h10: c = 7'h71;
      7'h11: c = 7'h77;
      7'h12: c = 7'h65;
      7'h13: c = 7'h72;
      7'h14: c = 7'h74;
      7'h15: c = 7'h79;
      7'h16: c = 7'h75;
      7'h17: c = 7'h69;
      7'h18: c = 7'h6F;
      7'h19: c = 7'h70;
      7'h1A: c = 7'h5B;
      7'h1B: c = 7'h5D;
      7'h1C: c = 7'h0A;
      7'h1E: c = 7'h61;
      7'h1F: c = 7'h73;
      7'h20: c = 7'h64;
      7'h21: c = 7'h66;
      7'h22: c = 7'h67;
      7'h23: c = 7'h68;
      7'h24: c = 7'h6A;
      7'h25: c = 7'h6B;
      7'h26: c = 7'h6C;
      7'h27: c = 7'h3B;
      7'h28: c = 7'h27;
      7'h29: c = 7'h60;
      7'h2B: c = 7'h5C;
      7'h2C: c = 7'h7A;
      7'h2D: c = 7'h78;
      7'h2E: c = 7'h63;
      7'h2F: c = 7'h76;
      7'h30: c = 7'h62;
      7'h31: c = 7'h6E;
      7'h32: c = 7'h6D;
      7'h33: c = 7'h2C;
      7'h34: c = 7'h2E;
      7'h35: c = 7'h2F;
      7'h37: c = 7'h2A;
      7'h39: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/sta_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module sta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sta_front.sv =====
// Front end: accepts input transactions and classifies them into commands.
module sta_front import sta_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [CODE_W-1:0] in_scan_code,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic [CHAR_W-1:0] ch;

  assign ch = set1_to_ascii(in_scan_code[CODE_W-2:0]);

  always_comb begin
    q_cmd.ch = ch;
    if (in_op == OP_READ) begin
      q_cmd.kind = CMD_READ;
    end else if (in_scan_code[CODE_W-1] || (ch == '0)) begin
      // release code or untranslated make code
      q_cmd.kind = CMD_NOP;
    end else begin
      q_cmd.kind = CMD_WRITE;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== rtl/sta_queue.sv =====
// Short command queue between the front end and the back end.
module sta_queue import sta_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t               entry_r [Q_DEPTH];
  logic [Q_IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [Q_IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = entry_r[rd_idx_r];

  function automatic logic [Q_IDX_W-1:0] wrap_inc(input logic [Q_IDX_W-1:0] i);
    return (i == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    wr_idx_nxt = push ? wrap_inc(wr_idx_r) : wr_idx_r;
    rd_idx_nxt = pop ? wrap_inc(rd_idx_r) : rd_idx_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_idx_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/sta_back.sv =====
// Back end: ring buffer pointers, character RAM and result register.
module sta_back import sta_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_char_valid,
  output logic              out_stored
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state_r, state_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_cv_r, out_cv_nxt;
  logic              out_st_r, out_st_nxt;
  logic              out_free;
  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  wr_ptr_inc, rd_ptr_inc;
  logic [CHAR_W-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_inc = ptr_inc(wr_ptr_r);
  assign rd_ptr_inc = ptr_inc(rd_ptr_r);
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_cv_nxt    = out_cv_r;
    out_st_nxt    = out_st_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop        = 1'b1;
          out_char_nxt = '0;
          out_cv_nxt   = 1'b0;
          out_st_nxt   = 1'b0;
          case (q_head.kind)
            CMD_WRITE: begin
              out_valid_nxt = 1'b1;
              if (wr_ptr_inc != rd_ptr_r) begin
                ram_we     = 1'b1;
                wr_ptr_nxt = wr_ptr_inc;
                out_st_nxt = 1'b1;
              end
            end
            CMD_READ: begin
              if (rd_ptr_r != wr_ptr_r) begin
                ram_re     = 1'b1;
                rd_ptr_nxt = rd_ptr_inc;
                state_nxt  = ST_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        // result slot was freed when the read was issued
        out_valid_nxt = 1'b1;
        out_char_nxt  = ram_rdata;
        out_cv_nxt    = 1'b1;
        out_st_nxt    = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_cv_r   <= out_cv_nxt;
    out_st_r   <= out_st_nxt;
  end

  sta_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (q_head.ch),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_char_out   = out_char_r;
  assign out_char_valid = out_cv_r;
  assign out_stored     = out_st_r;

endmodule

// ===== rtl/scancode_to_ascii_fifo_unit.sv =====
// Top level of the scan code to ASCII ring buffer unit.
// Flow: an accepted transaction is written into the queue, popped by the back end and
//   registered as the result (store, drop or empty read); a read of a buffered
//   character also waits on the registered RAM read port in ST_READ. A stalled output
//   or a backlog of queued reads delays the result. Throughput: one scan code per cycle
//   while the output is not stalled; the back end takes no new command during ST_READ.
// Reset: synchronous, active low; clears pointers, queue and state. RAM is not cleared.
module scancode_to_ascii_fifo_unit import sta_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [CODE_W-1:0] in_scan_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_char_valid,
  output logic              out_stored
);

  // Front end to queue
  logic q_push;
  cmd_t q_cmd;
  logic q_full;

  // Queue to back end
  cmd_t q_head;
  logic q_empty;
  logic q_pop;

  // Translate each input transaction into a command: NOP for release codes
  // and untranslated make codes, WRITE with the character, or READ.
  sta_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_scan_code (in_scan_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // Two-entry queue decouples input acceptance from ring buffer work.
  sta_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Ring buffer: full when advancing the write pointer would hit the read
  // pointer, empty when they are equal. One result transaction per command.
  sta_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_out   (out_char_out),
    .out_char_valid (out_char_valid),
    .out_stored     (out_stored)
  );

  // Never pop a command from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // An accepted transaction leaves the queue non-empty in the next cycle.
  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !q_empty)
    else $error("accepted transaction not queued");

  // A result is either a read result or a store report, never both.
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_char_valid && out_stored))
    else $error("result flags both set");

  // No character is reported without a successful read.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_char_valid) |-> (out_char_out == '0))
    else $error("character nonzero without valid read");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the scan code to ASCII ring buffer unit.
`timescale 1ns / 100ps

module tb;
  import sta_pkg::*;

  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_ITEMS   = 750;
  localparam int DRAIN_CYCLES   = 8;     // extra quiet cycles to catch stray results
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before we call it hung

  localparam logic [CODE_W-1:0] RELEASE_BIT = 8'h80;

  // One result transaction as seen on the out_ channel.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              ok;
    logic              stored;
  } ascii_res_t;

  // Directed stimulus row; when typed is set the expectation is taken from the row.
  typedef struct packed {
    logic              op;
    logic [CODE_W-1:0] code;
    logic              typed;
    ascii_res_t        want;
  } dir_row_t;

  typedef enum int {FILL_BURST, DRAIN_BURST, MIXED_BURST} burst_mode_t;

  localparam ascii_res_t NO_RESULT = '{7'h00, 1'b0, 1'b0};
  localparam ascii_res_t STORED    = '{7'h00, 1'b0, 1'b1};

  // Set 1 make codes 0x00..0x3F, US layout. Codes 0x40..0x7F translate to nothing.
  localparam logic [CHAR_W-1:0] KEYMAP [64] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Directed part: empty reads, releases, untranslated codes, stores, then pops in order.
  localparam dir_row_t DIRECTED [25] = '{
    '{OP_READ, 8'h00, 1'b1, NO_RESULT},             // read right after reset: empty
    '{OP_READ, 8'hFF, 1'b1, NO_RESULT},             // scan code ignored on a read
    '{OP_SCAN, 8'h80, 1'b1, NO_RESULT},             // release, lowest
    '{OP_SCAN, 8'hFF, 1'b1, NO_RESULT},             // release, all ones
    '{OP_SCAN, 8'h00, 1'b1, NO_RESULT},             // code zero has no character
    '{OP_SCAN, 8'h7F, 1'b1, NO_RESULT},             // top make code, beyond the table
    '{OP_SCAN, 8'h40, 1'b1, NO_RESULT},             // first code past the listed 64
    '{OP_SCAN, 8'h1D, 1'b1, NO_RESULT},             // hole in the table (ctrl)
    '{OP_SCAN, 8'h01, 1'b1, STORED},                // escape
    '{OP_SCAN, 8'h39, 1'b1, STORED},                // space
    '{OP_SCAN, 8'h1C, 1'b1, STORED},                // enter
    '{OP_SCAN, 8'h81, 1'b1, NO_RESULT},             // release of escape
    '{OP_SCAN, 8'h35, 1'b1, STORED},                // slash
    '{OP_READ, 8'h00, 1'b1, '{7'h1B, 1'b1, 1'b0}},
    '{OP_READ, 8'h55, 1'b1, '{7'h20, 1'b1, 1'b0}},
    '{OP_READ, 8'hAA, 1'b1, '{7'h0A, 1'b1, 1'b0}},
    '{OP_READ, 8'h00, 1'b1, '{7'h2F, 1'b1, 1'b0}},
    '{OP_READ, 8'h00, 1'b1, NO_RESULT},             // drained again
    '{OP_SCAN, 8'h10, 1'b0, NO_RESULT},
    '{OP_SCAN, 8'h2C, 1'b0, NO_RESULT},
    '{OP_READ, 8'h00, 1'b0, NO_RESULT},
    '{OP_SCAN, 8'h0E, 1'b0, NO_RESULT},
    '{OP_READ, 8'h00, 1'b0, NO_RESULT},
    '{OP_READ, 8'h00, 1'b0, NO_RESULT},
    '{OP_READ, 8'h00, 1'b0, NO_RESULT}
  };

  logic              clk;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_op        = OP_SCAN;
  logic [CODE_W-1:0] in_scan_code = '0;
  logic              out_stall    = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char_out;
  logic              out_char_valid;
  logic              out_stored;

  // Knobs for the current phase, in percent.
  int idle_pct  = 0;
  int stall_pct = 0;

  int n_errors     = 0;
  int quiet_cycles = 0;

  // Results still owed by the block, oldest first.
  ascii_res_t pending_ascii [$];

  // Shadow of the ring buffer.
  logic [CHAR_W-1:0] shadow_ring [BUFFER_DEPTH];
  logic [PTR_W-1:0]  shadow_rd = '0;
  logic [PTR_W-1:0]  shadow_wr = '0;

  scancode_to_ascii_fifo_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_scan_code   (in_scan_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_out   (out_char_out),
    .out_char_valid (out_char_valid),
    .out_stored     (out_stored)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % BUFFER_DEPTH);
  endfunction

  // Applies one accepted transaction to the shadow buffer and returns its result.
  function automatic ascii_res_t predict_ascii(input logic op, input logic [CODE_W-1:0] code);
    ascii_res_t        res;
    logic [CHAR_W-1:0] ch;
    res = NO_RESULT;
    if (op == OP_SCAN) begin
      // releases and codes past the table give no character
      ch = ((code & RELEASE_BIT) != 0 || code[6]) ? '0 : KEYMAP[code[5:0]];
      if (ch != 0 && ring_next(shadow_wr) != shadow_rd) begin
        shadow_ring[shadow_wr] = ch;
        shadow_wr = ring_next(shadow_wr);
        res.stored = 1'b1;
      end
      // a full buffer drops the character and the result shows it as not stored
    end else if (shadow_rd != shadow_wr) begin
      res.ch = shadow_ring[shadow_rd];
      res.ok = 1'b1;
      shadow_rd = ring_next(shadow_rd);
    end
    return res;
  endfunction

  // Mostly make codes in the listed range, some releases, some anything.
  function automatic logic [CODE_W-1:0] pick_scan_code(input int make_pct);
    int r;
    r = $urandom_range(99);
    if (r < make_pct) return CODE_W'($urandom_range(63));
    if (r < make_pct + (100 - make_pct) / 2) return CODE_W'($urandom_range(255, 128));
    return CODE_W'($urandom_range(255));
  endfunction

  // Offers one transaction, holds it through any stall, and books its expectation
  // at the edge where it is accepted.
  task automatic send_key_event(input logic op, input logic [CODE_W-1:0] code,
                                input logic typed, input ascii_res_t want);
    ascii_res_t model;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_scan_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model = predict_ascii(op, code);
    pending_ascii.push_back(typed ? want : model);
  endtask

  // Result side: checks every delivered result against the oldest expectation,
  // then picks the stall for the next cycle.
  always @(posedge clk) begin : result_check
    ascii_res_t got;
    ascii_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_char_out, out_char_valid, out_stored};
        if (pending_ascii.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h/%b/%b",
                   $time, got.ch, got.ok, got.stored);
          n_errors++;
        end else begin
          want = pending_ascii.pop_front();
          if (got.ch !== want.ch) begin
            $display("%0t: char_out mismatch, expected %h, actual %h", $time, want.ch, got.ch);
            n_errors++;
          end
          if (got.ok !== want.ok) begin
            $display("%0t: char_valid mismatch, expected %b, actual %b",
                     $time, want.ok, got.ok);
            n_errors++;
          end
          if (got.stored !== want.stored) begin
            $display("%0t: stored mismatch, expected %b, actual %b",
                     $time, want.stored, got.stored);
            n_errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Hang detector: any cycle with a transaction on either side resets the count.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    burst_mode_t mode;
    int          burst_len;
    int          read_pct;
    int          make_pct;
    int          sent;
    logic        op;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      send_key_event(row.op, row.code, row.typed, row.want);
    end

    // Random part in four phases: no idling, sender gaps, receiver stalls, both.
    // Traffic comes in bursts that fill, drain or mix, so the buffer swings
    // between empty and full; phases 0 and 2 open with a fill long enough to
    // overflow it.
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      for (int b = 0; sent < (ph + 1) * RANDOM_ITEMS / 4; b++) begin
        if (b == 0 && (ph == 0 || ph == 2)) begin
          mode      = FILL_BURST;
          burst_len = 200;
        end else begin
          mode      = burst_mode_t'($urandom_range(2));
          burst_len = $urandom_range(80, 10);
        end
        case (mode)
          FILL_BURST:  begin read_pct = 3;  make_pct = 92; end
          DRAIN_BURST: begin read_pct = 90; make_pct = 70; end
          default:     begin read_pct = 50; make_pct = 70; end
        endcase
        repeat (burst_len) begin
          op = ($urandom_range(99) < read_pct) ? OP_READ : OP_SCAN;
          send_key_event(op, (op == OP_READ) ? CODE_W'($urandom_range(255))
                                             : pick_scan_code(make_pct),
                         1'b0, NO_RESULT);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    // Let the block deliver what it owes, then watch a few cycles for strays.
    while (pending_ascii.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
